>>> hw/rtl/lpcd_pkg.sv
// Package: item types, codes, constants and CRC-32 byte update for the deframer.
`default_nettype none

package lpcd_pkg;

  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_RESIDUE = 32'h2144_DF1C;

  localparam int unsigned GAP_W     = 20;
  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(100000);
  localparam logic [GAP_W-1:0] IDLE_MAX  = {GAP_W{1'b1}};

  localparam logic [2:0] CHECK_BYTES = 3'd4;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic {
    REG_CHECK_CRC = 1'b0,
    REG_GAP_LIMIT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_payload;
    logic       frame_end;
    logic       frame_ok;
  } out_item_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } q_item_t;

  typedef struct packed {
    logic             check_crc;
    logic [GAP_W-1:0] gap_limit;
  } cfg_t;

  // Reflected CRC-32, one byte, LSB first.
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lpcd_front.sv
// Front stage: accepts input items and classifies them into queue entries.
`default_nettype none

module lpcd_front import lpcd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          q_valid_o,
  input  wire logic     q_ready_i,
  output q_item_t       q_item_o
);

  logic    valid_q, valid_d;
  q_item_t item_q, item_d;
  logic    accept;

  assign in_ready_o = !valid_q || q_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (accept) begin
      valid_d      = 1'b1;
      item_d.op    = (in_item_i.kind == KIND_TICK) ? OP_TICK : OP_BYTE;
      item_d.data  = in_item_i.data_byte;
    end else if (q_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign q_valid_o = valid_q;
  assign q_item_o  = item_q;

endmodule

`default_nettype wire

>>> hw/rtl/lpcd_fifo.sv
// Short item queue between the front and back stages.
`default_nettype none

module lpcd_fifo import lpcd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  output logic         ready_o,
  input  wire q_item_t item_i,
  output logic         valid_o,
  input  wire logic    ready_i,
  output q_item_t      item_o
);

  q_item_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lpcd_back.sv
// Back stage: frame state machine, CRC-32 check, gap timer and result register.
`default_nettype none

module lpcd_back import lpcd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_t    cfg_i,
  input  wire logic    q_valid_i,
  output logic         q_ready_o,
  input  wire q_item_t q_item_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output out_item_t    out_item_o
);

  phase_e           phase_q, phase_d;
  logic [7:0]       bytes_left_q, bytes_left_d;
  logic [31:0]      crc_q, crc_d;
  logic [2:0]       check_left_q, check_left_d;
  logic [GAP_W-1:0] idle_q, idle_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  logic             pop;
  logic             res_valid;
  out_item_t        res;
  logic [31:0]      crc_next;
  logic [GAP_W-1:0] idle_inc;
  logic [7:0]       bl_dec;
  logic [2:0]       cl_dec;

  assign q_ready_o = !out_valid_q || out_ready_i;
  assign pop       = q_valid_i && q_ready_o;
  assign crc_next  = crc32_byte(crc_q, q_item_i.data);
  assign idle_inc  = (idle_q != IDLE_MAX) ? idle_q + GAP_W'(1) : idle_q;
  assign bl_dec    = bytes_left_q - 8'd1;
  assign cl_dec    = check_left_q - 3'd1;

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    crc_d        = crc_q;
    check_left_d = check_left_q;
    idle_d       = idle_q;
    res_valid    = 1'b0;
    res          = '0;
    if (pop) begin
      case (q_item_i.op)
        OP_TICK: begin
          if (phase_q == PH_PAYLOAD || phase_q == PH_CHECK) begin
            if (idle_inc >= cfg_i.gap_limit) begin
              phase_d       = PH_WAIT;
              bytes_left_d  = '0;
              check_left_d  = '0;
              idle_d        = '0;
              res_valid     = 1'b1;
              res.frame_end = 1'b1;
            end else begin
              idle_d = idle_inc;
            end
          end else begin
            idle_d = '0;
          end
        end
        default: begin
          idle_d = '0;
          case (phase_q)
            PH_PAYLOAD: begin
              crc_d            = crc_next;
              bytes_left_d     = bl_dec;
              res_valid        = 1'b1;
              res.payload_byte = q_item_i.data;
              res.is_payload   = 1'b1;
              if (bl_dec == '0) begin
                if (cfg_i.check_crc) begin
                  phase_d      = PH_CHECK;
                  check_left_d = CHECK_BYTES;
                end else begin
                  phase_d       = PH_WAIT;
                  res.frame_end = 1'b1;
                  res.frame_ok  = 1'b1;
                end
              end
            end
            PH_CHECK: begin
              crc_d        = crc_next;
              check_left_d = cl_dec;
              if (cl_dec == '0) begin
                phase_d       = PH_WAIT;
                res_valid     = 1'b1;
                res.frame_end = 1'b1;
                res.frame_ok  = ((crc_next ^ CRC_INIT) == CRC_RESIDUE);
              end
            end
            default: begin
              if (q_item_i.data != 8'd0) begin
                bytes_left_d = q_item_i.data;
                crc_d        = CRC_INIT;
                phase_d      = PH_PAYLOAD;
              end
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (pop) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_item_d = res;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_WAIT;
      bytes_left_q <= '0;
      crc_q        <= CRC_INIT;
      check_left_q <= '0;
      idle_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      crc_q        <= crc_d;
      check_left_q <= check_left_d;
      idle_q       <= idle_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> bytes_left_q != '0)
    else $error("payload phase with no bytes left");

  a_check_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CHECK |-> (check_left_q != '0 && check_left_q <= CHECK_BYTES))
    else $error("check phase count out of range");

  a_wait_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_WAIT |-> idle_q == '0)
    else $error("idle count running while no frame is open");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_item_q))
    else $error("pending result overwritten");

  a_ok_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && res_valid && res.frame_ok |-> res.frame_end)
    else $error("good verdict without frame end");

endmodule

`default_nettype wire

>>> hw/rtl/length_prefixed_crc32_deframer.sv
// Top level: length-prefixed CRC-32 deframer with APB configuration port.
//
// Each input item is a received byte or a time tick; a frame is a nonzero length
// byte, that many payload bytes passed on one result each, and in checked mode
// four CRC-32 bytes whose fourth gives a verdict-only result. Sustained input rate
// is one item per clock while out_ready_i stays high; the back stage does the
// byte-wise CRC update, counters and gap compare combinationally for each item.
// From input accept to result valid an item passes the front register, the
// four-entry queue and the result register. APB: check_crc at 0x0, gap_limit
// at 0x4, pready always high; write registers only while the block is idle.
`default_nettype none

module length_prefixed_crc32_deframer import lpcd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_item_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     cfg_we;
  logic     fq_valid, fq_ready;
  q_item_t  fq_item;
  logic     bq_valid, bq_ready;
  q_item_t  bq_item;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (reg_idx)
        REG_CHECK_CRC: cfg_d.check_crc = pwdata[0];
        REG_GAP_LIMIT: cfg_d.gap_limit = pwdata[GAP_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CHECK_CRC: prdata = {{(APB_DATA_W-1){1'b0}}, cfg_q.check_crc};
      REG_GAP_LIMIT: prdata = {{(APB_DATA_W-GAP_W){1'b0}}, cfg_q.gap_limit};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_crc <= 1'b0;
      cfg_q.gap_limit <= GAP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lpcd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_item_o   (fq_item)
  );

  lpcd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fq_valid),
    .ready_o (fq_ready),
    .item_i  (fq_item),
    .valid_o (bq_valid),
    .ready_i (bq_ready),
    .item_o  (bq_item)
  );

  lpcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (bq_valid),
    .q_ready_o   (bq_ready),
    .q_item_i    (bq_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

>>> dv/tb_length_prefixed_crc32_deframer.sv
// Testbench for the length-prefixed CRC-32 deframer: frame tracker, stimulus and checks.
`timescale 1ns / 100ps

package lpcd_tb_pkg;
  import lpcd_pkg::*;

  // Reflected CRC-32, folded in one data bit at a time.
  function automatic logic [31:0] crc32_fold(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ ((c[0] ^ b[k]) ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  class frame_tracker;
    phase_e           phase;
    logic [7:0]       bytes_left;
    logic [31:0]      crc;
    logic [2:0]       check_left;
    logic [GAP_W-1:0] idle_ticks;
    logic             check_on;
    logic [GAP_W-1:0] gap_limit;
    out_item_t        due_results[$];
    int unsigned      fail_count;

    function new();
      phase      = PH_WAIT;
      bytes_left = '0;
      crc        = CRC_INIT;
      check_left = '0;
      idle_ticks = '0;
      check_on   = 1'b0;
      gap_limit  = GAP_RESET;
      fail_count = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] val);
      if (idx == REG_CHECK_CRC) begin
        check_on = val[0];
      end else begin
        gap_limit = val[GAP_W-1:0];
      end
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction

    // Advance the frame state by one accepted item and queue what it produces.
    function void take_rx(in_item_t it);
      out_item_t res;
      res = '0;
      if (it.kind == KIND_TICK) begin
        if (phase == PH_WAIT) begin
          idle_ticks = '0;
          return;
        end
        if (idle_ticks != IDLE_MAX) idle_ticks++;
        if (idle_ticks >= gap_limit) begin
          phase      = PH_WAIT;
          bytes_left = '0;
          check_left = '0;
          idle_ticks = '0;
          res.frame_end = 1'b1;
          due_results.push_back(res);
        end
        return;
      end
      idle_ticks = '0;
      if (phase == PH_WAIT) begin
        if (it.data_byte != 8'd0) begin
          bytes_left = it.data_byte;
          crc        = CRC_INIT;
          phase      = PH_PAYLOAD;
        end
        return;
      end
      crc = crc32_fold(crc, it.data_byte);
      if (phase == PH_PAYLOAD) begin
        bytes_left--;
        res.payload_byte = it.data_byte;
        res.is_payload   = 1'b1;
        if (bytes_left == 8'd0) begin
          if (check_on) begin
            phase      = PH_CHECK;
            check_left = CHECK_BYTES;
          end else begin
            phase        = PH_WAIT;
            res.frame_end = 1'b1;
            res.frame_ok  = 1'b1;
          end
        end
        due_results.push_back(res);
        return;
      end
      check_left--;
      if (check_left == 3'd0) begin
        phase         = PH_WAIT;
        res.frame_end = 1'b1;
        res.frame_ok  = (~crc == CRC_RESIDUE);
        due_results.push_back(res);
      end
    endfunction

    function void field_cmp(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        fail_count++;
      end
    endfunction

    function void check_out(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result expected none got %h", $time, got);
        fail_count++;
        return;
      end
      want = due_results.pop_front();
      field_cmp("payload_byte", want.payload_byte, got.payload_byte);
      field_cmp("is_payload", want.is_payload, got.is_payload);
      field_cmp("frame_end", want.frame_end, got.frame_end);
      field_cmp("frame_ok", want.frame_ok, got.frame_ok);
    endfunction
  endclass

endpackage

module tb_length_prefixed_crc32_deframer;
  import lpcd_pkg::*;
  import lpcd_tb_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned N_PHASES     = 8;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;

  frame_tracker tracker = new();
  in_item_t     stim_q[$];
  bit           cur_check = 1'b0;
  int unsigned  cur_gap = 100000;
  int unsigned  no_gap_left = 0;
  bit           hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  length_prefixed_crc32_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  function automatic int unsigned src_gap();
    int unsigned r;
    if (no_gap_left != 0) begin
      no_gap_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      no_gap_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put_byte(logic [7:0] b);
    stim_q.push_back({KIND_BYTE, b});
  endfunction

  function automatic void put_ticks(int unsigned n);
    repeat (n) stim_q.push_back({KIND_TICK, 8'($urandom)});
  endfunction

  // Length byte, payload, optional FCS; cut_off ends it early with an idle gap.
  function automatic void put_frame(int unsigned len, bit with_fcs, bit bad_fcs, bit cut_off);
    logic [7:0]  body[$];
    logic [31:0] crc;
    int unsigned cut, safe;
    crc = CRC_INIT;
    for (int i = 0; i < len; i++) begin
      body.push_back(8'($urandom));
      crc = crc32_fold(crc, body[i]);
    end
    if (with_fcs) begin
      crc = ~crc;
      if (bad_fcs) crc ^= 32'd1 << $urandom_range(0, 31);
      for (int k = 0; k < 4; k++) body.push_back(crc[8*k +: 8]);
    end
    cut  = cut_off ? $urandom_range(0, body.size() - 1) : body.size();
    safe = (cur_gap > 3) ? 3 : cur_gap - 1;
    put_byte(8'(len));
    for (int i = 0; i < body.size(); i++) begin
      if (i == cut) begin
        put_ticks(cur_gap);
        return;
      end
      if (safe != 0 && $urandom_range(0, 9) == 0) put_ticks($urandom_range(1, safe));
      put_byte(body[i]);
    end
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 97) return $urandom_range(7, 40);
    return $urandom_range(200, 255);
  endfunction

  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = src_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid = 1'b0;
    end
    @(negedge clk_i);
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk_i); while (!in_ready);
    tracker.take_rx(it);
  endtask

  task automatic send_all();
    while (stim_q.size() != 0) send_item(stim_q.pop_front());
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_W'(4 * int'(idx));
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    tracker.set_reg(idx, val);
    if (idx == REG_CHECK_CRC) begin
      cur_check = val[0];
    end else begin
      cur_gap = (val[GAP_W-1:0] == '0) ? 1 : int'(val[GAP_W-1:0]);
    end
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned framed, r;
    framed = 0;
    while (framed < n) begin
      r = $urandom_range(0, 99);
      if (r < 82) begin
        put_frame(pick_len(), cur_check, $urandom_range(0, 6) == 0,
                  cur_gap <= 64 && $urandom_range(0, 9) == 0);
        framed += stim_q.size();
      end else if (r < 89) begin
        put_ticks($urandom_range(1, 4));
      end else if (r < 93) begin
        put_byte(8'd0);
      end else if (r < 97) begin
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
      end else begin
        put_frame(pick_len(), !cur_check, 1'b0, 1'b0);
        framed += stim_q.size();
      end
      send_all();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) tracker.check_out(out_item);
  end

  initial begin : ready_drive
    int unsigned mode, len;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          out_ready = 1'b0;
        end
        hold_req = 1'b0;
      end
      mode = $urandom_range(0, 9);
      len  = $urandom_range(8, 80);
      if (mode == 9) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 6);
      end
      repeat (len) begin
        @(negedge clk_i);
        if (mode < 5) begin
          out_ready = 1'b1;
        end else if (mode < 9) begin
          out_ready = ($urandom_range(0, 3) != 0);
        end else begin
          out_ready = 1'b0;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_length_prefixed_crc32_deframer NOT OK");
    $finish;
  end

  initial begin : main
    logic [31:0] fcs;
    bit          chk_sel;
    int unsigned gap_sel;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: an idle tick, zero length, one-byte frame, frame left open
    put_ticks(1);
    put_byte(8'd0);
    put_byte(8'd1);
    put_byte(8'hFF);
    put_byte(8'd2);
    put_byte(8'h00);
    send_all();
    settle();

    // checking turned on mid-frame, then bad FCS and gap aborts
    reg_write(REG_CHECK_CRC, 32'd1);
    reg_write(REG_GAP_LIMIT, 32'd1);
    fcs = ~crc32_fold(crc32_fold(CRC_INIT, 8'h00), 8'h80);
    put_byte(8'h80);
    for (int k = 0; k < 4; k++) put_byte(fcs[8*k +: 8]);
    put_frame(1, 1'b1, 1'b1, 1'b0);
    put_byte(8'd3);
    put_byte(8'h5A);
    put_ticks(2);
    send_all();
    settle();

    reg_write(REG_GAP_LIMIT, 32'd0);
    put_byte(8'd1);
    put_ticks(1);
    send_all();
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin chk_sel = 1'b1; gap_sel = 1000000; end
        1: begin chk_sel = 1'b1; gap_sel = 4; end
        2: begin chk_sel = 1'b0; gap_sel = 2; end
        3: begin chk_sel = 1'b1; gap_sel = 1; end
        4: begin chk_sel = 1'b0; gap_sel = 30; end
        5: begin chk_sel = 1'b1; gap_sel = $urandom_range(1, 64); end
        6: begin chk_sel = 1'b0; gap_sel = $urandom_range(1, 64); end
        default: begin chk_sel = 1'b1; gap_sel = 100000; end
      endcase
      reg_write(REG_CHECK_CRC, 32'(chk_sel));
      reg_write(REG_GAP_LIMIT, 32'(gap_sel));
      if (p == 0) begin
        put_frame(255, cur_check, 1'b0, 1'b0);
        send_all();
      end
      if (p == 4) hold_req = 1'b1;
      if (p == 3) begin
        random_phase(100);
        settle();
        random_phase(100);
      end else begin
        random_phase(200);
      end
      settle();
    end

    if (tracker.fail_count == 0 && tracker.outstanding() == 0) begin
      $display("tb_length_prefixed_crc32_deframer OK");
    end else begin
      $display("tb_length_prefixed_crc32_deframer NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/lpcd_pkg.sv
hw/rtl/lpcd_front.sv
hw/rtl/lpcd_fifo.sv
hw/rtl/lpcd_back.sv
hw/rtl/length_prefixed_crc32_deframer.sv
dv/tb_length_prefixed_crc32_deframer.sv
